FILE: rtl/core/bapp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bapp_pkg
// Shared types and constants for the buzzer alert pattern player.
// ----------------------------------------------------------------------------
package bapp_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned IN_USED_W  = 39;
    localparam int unsigned OUT_DATA_W = 8;

    // pattern length and bit period in ms
    localparam logic [WORD_W-1:0] PLAY_LEN_MS = 32'd3200;
    localparam int unsigned       BIT_MS      = 100;

    // elapsed / 100 for elapsed < 3200: (elapsed * 5243) >> 19, exact in range
    localparam int unsigned    ELAP_W      = 12;
    localparam int unsigned    RECIP_W     = 13;
    localparam logic [12:0]    RECIP_100   = 13'd5243;
    localparam int unsigned    RECIP_SHIFT = 19;
    localparam int unsigned    BIT_IDX_W   = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SINGLE      = 3'd0,
        CFG_DOUBLE      = 3'd1,
        CFG_ARMING      = 3'd2,
        CFG_EKF_BAD     = 3'd3,
        CFG_GYRO_INIT   = 3'd4,
        CFG_PREARM_GOOD = 3'd5,
        CFG_MIN_GAP     = 3'd6,
        CFG_ACTIVE_LVL  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [WORD_W-1:0] single_pattern;
        logic [WORD_W-1:0] double_pattern;
        logic [WORD_W-1:0] arming_pattern;
        logic [WORD_W-1:0] ekf_bad_pattern;
        logic [WORD_W-1:0] gyro_init_pattern;
        logic [WORD_W-1:0] prearm_good_pattern;
        logic [WORD_W-1:0] min_gap_ms;
    } t_cfg;

    typedef struct packed {
        logic              mode;
        logic [WORD_W-1:0] now_ms;
        logic              arm_failed_event;
        logic              gyro_cal_flag;
        logic              prearm_ok_flag;
        logic              armed_flag;
        logic              ekf_bad_flag;
        logic              lost_flag;
        logic              battery_fs_flag;
    } t_item;

    typedef struct packed {
        logic seen_gyro_cal;
        logic seen_prearm_ok;
        logic seen_armed;
        logic seen_ekf_bad;
    } t_seen;

    // selection result: whether a pattern starts and with which word
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] word;
        t_seen             seen;
    } t_sel;

    typedef struct packed {
        logic [WORD_W-1:0] pattern_word;
        logic [WORD_W-1:0] start_time;
        logic              buzz_on;
    } t_play;

endpackage

FILE: rtl/core/buzzer_alert_pattern_player.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buzzer_alert_pattern_player
// Plays 32-bit buzzer alert words chosen by priority from status ticks.
//
//  channel   dir  payload (low bit first)
//  s_axis    in   tdata: now_ms, arm_failed, gyro_cal, prearm_ok, armed,
//                        ekf_bad, lost, battery_fs; tuser: mode
//  m_axis    out  tdata: pin_level, sounding, busy_res
//  cfg       in   i_cfg_wr_en / i_cfg_index / i_cfg_wdata, write only
//
//  One word accepted per cycle while the result register is free or being read;
//  each word goes through the input register, then the result register.
//  The status state is updated in the cycle a word moves into the result
//  register, so the next word sees it at once.
//  Synchronous active-low reset clears state and sets active_level to 1.
//  A stalled result register holds the input register, which then drops ready.
// ----------------------------------------------------------------------------
module buzzer_alert_pattern_player (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // now_ms[31:0], arm_failed, gyro_cal, prearm_ok, armed, ekf_bad, lost,
    // battery_fs, pad
    input  logic [bapp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // mode
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // pin_level, sounding, busy_res, pad
    output logic [bapp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                              i_cfg_wr_en,
    input  logic [bapp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bapp_pkg::WORD_W-1:0]       i_cfg_wdata
);

    bapp_pkg::t_cfg                   r_cfg;
    logic                             r_active;

    logic                             r_in_valid;
    logic [bapp_pkg::IN_USED_W-1:0]   r_in_data;
    logic                             r_in_mode;

    logic [bapp_pkg::WORD_W-1:0]      r_pattern_word;
    logic [bapp_pkg::WORD_W-1:0]      r_start_time;
    logic                             r_buzz_on;
    bapp_pkg::t_seen                  r_seen;

    logic                             r_out_valid;
    logic                             r_out_pin;
    logic                             r_out_sounding;
    logic                             r_out_busy;

    logic                             w_advance;
    bapp_pkg::t_item                  w_item;
    bapp_pkg::t_sel                   w_sel;
    bapp_pkg::t_play                  w_cur;
    bapp_pkg::t_play                  n_play;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg    <= '0;
            r_active <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (bapp_pkg::t_cfg_idx'(i_cfg_index))
                bapp_pkg::CFG_SINGLE:      r_cfg.single_pattern      <= i_cfg_wdata;
                bapp_pkg::CFG_DOUBLE:      r_cfg.double_pattern      <= i_cfg_wdata;
                bapp_pkg::CFG_ARMING:      r_cfg.arming_pattern      <= i_cfg_wdata;
                bapp_pkg::CFG_EKF_BAD:     r_cfg.ekf_bad_pattern     <= i_cfg_wdata;
                bapp_pkg::CFG_GYRO_INIT:   r_cfg.gyro_init_pattern   <= i_cfg_wdata;
                bapp_pkg::CFG_PREARM_GOOD: r_cfg.prearm_good_pattern <= i_cfg_wdata;
                bapp_pkg::CFG_MIN_GAP:     r_cfg.min_gap_ms          <= i_cfg_wdata;
                bapp_pkg::CFG_ACTIVE_LVL:  r_active                  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata[bapp_pkg::IN_USED_W-1:0];
            r_in_mode <= s_axis_tuser;
        end
    end

    assign w_item.mode             = r_in_mode;
    assign w_item.now_ms           = r_in_data[31:0];
    assign w_item.arm_failed_event = r_in_data[32];
    assign w_item.gyro_cal_flag    = r_in_data[33];
    assign w_item.prearm_ok_flag   = r_in_data[34];
    assign w_item.armed_flag       = r_in_data[35];
    assign w_item.ekf_bad_flag     = r_in_data[36];
    assign w_item.lost_flag        = r_in_data[37];
    assign w_item.battery_fs_flag  = r_in_data[38];

    assign w_cur.pattern_word = r_pattern_word;
    assign w_cur.start_time   = r_start_time;
    assign w_cur.buzz_on      = r_buzz_on;

    bapp_select u_select (
        .i_item       (w_item),
        .i_cfg        (r_cfg),
        .i_start_time (r_start_time),
        .i_seen       (r_seen),
        .o_sel        (w_sel)
    );

    bapp_play u_play (
        .i_item (w_item),
        .i_sel  (w_sel),
        .i_cur  (w_cur),
        .o_next (n_play)
    );

    // player state, updated as the word moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_word <= '0;
            r_start_time   <= '0;
            r_buzz_on      <= 1'b0;
            r_seen         <= '0;
        end else if (w_advance) begin
            r_pattern_word <= n_play.pattern_word;
            r_start_time   <= n_play.start_time;
            r_buzz_on      <= n_play.buzz_on;
            r_seen         <= w_sel.seen;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_pin      <= n_play.buzz_on ? r_active : ~r_active;
            r_out_sounding <= n_play.buzz_on;
            r_out_busy     <= (n_play.pattern_word != '0);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(bapp_pkg::OUT_DATA_W-3){1'b0}},
                            r_out_busy, r_out_sounding, r_out_pin};

`ifndef SYNTH
    // the pending result matches the player state it was taken from
    a_busy_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_busy == (r_pattern_word != '0)))
        else $error("busy_res disagrees with pattern state");

    a_sound_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_sounding == r_buzz_on))
        else $error("sounding disagrees with buzzer state");

    // the pre-arm pass is latched once and never cleared
    a_prearm_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !$fell(r_seen.seen_prearm_ok))
        else $error("seen_prearm_ok cleared");

    // a held input word is not dropped while the result side stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> r_in_valid)
        else $error("input word lost under stall");

    // silence when a playing pattern runs out with nothing new started
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && !w_item.mode && !w_sel.start && n_play.pattern_word == '0
         && r_pattern_word != '0) |-> !n_play.buzz_on)
        else $error("buzzer left on after pattern end");
`endif

endmodule

FILE: rtl/core/bapp_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bapp_select
// Priority selection of the pattern to start on one update word.
// ----------------------------------------------------------------------------
module bapp_select (
    input  bapp_pkg::t_item               i_item,
    input  bapp_pkg::t_cfg                i_cfg,
    input  logic [bapp_pkg::WORD_W-1:0]   i_start_time,
    input  bapp_pkg::t_seen               i_seen,
    output bapp_pkg::t_sel                o_sel
);

    logic [bapp_pkg::WORD_W-1:0] w_since;
    logic                        w_gap_ok;

    assign w_since  = i_item.now_ms - i_start_time;
    assign w_gap_ok = (w_since >= i_cfg.min_gap_ms);

    always_comb begin
        o_sel       = '0;
        o_sel.seen  = i_seen;
        if (i_item.mode) begin
            // init: only the armed flag is latched
            o_sel.seen.seen_armed = i_item.armed_flag;
        end else if (i_item.arm_failed_event) begin
            o_sel.start = 1'b1;
            o_sel.word  = i_cfg.single_pattern;
        end else if (w_gap_ok) begin
            if (i_seen.seen_gyro_cal != i_item.gyro_cal_flag) begin
                o_sel.seen.seen_gyro_cal = i_item.gyro_cal_flag;
                o_sel.start              = 1'b1;
                o_sel.word               = i_cfg.gyro_init_pattern;
            end
            if (i_item.prearm_ok_flag && !i_seen.seen_prearm_ok) begin
                o_sel.seen.seen_prearm_ok = 1'b1;
                o_sel.start               = 1'b1;
                o_sel.word                = i_cfg.prearm_good_pattern;
            end
            // later starts override earlier ones
            if (i_seen.seen_armed != i_item.armed_flag) begin
                o_sel.seen.seen_armed = i_item.armed_flag;
                o_sel.start           = 1'b1;
                o_sel.word            = i_item.armed_flag ? i_cfg.arming_pattern
                                                          : i_cfg.single_pattern;
            end else if (i_seen.seen_ekf_bad != i_item.ekf_bad_flag) begin
                o_sel.seen.seen_ekf_bad = i_item.ekf_bad_flag;
                if (i_item.ekf_bad_flag) begin
                    o_sel.start = 1'b1;
                    o_sel.word  = i_cfg.ekf_bad_pattern;
                end
            end else if (i_item.lost_flag) begin
                o_sel.start = 1'b1;
                o_sel.word  = i_cfg.double_pattern;
            end else if (i_item.battery_fs_flag) begin
                o_sel.start = 1'b1;
                o_sel.word  = i_cfg.single_pattern;
            end
        end
    end

endmodule

FILE: rtl/core/bapp_play.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bapp_play
// Pattern playback: picks the current bit of the word from elapsed time.
// ----------------------------------------------------------------------------
module bapp_play (
    input  bapp_pkg::t_item               i_item,
    input  bapp_pkg::t_sel                i_sel,
    input  bapp_pkg::t_play               i_cur,
    output bapp_pkg::t_play               o_next
);

    logic [bapp_pkg::WORD_W-1:0]                          w_word;
    logic [bapp_pkg::WORD_W-1:0]                          w_stime;
    logic [bapp_pkg::WORD_W-1:0]                          w_elapsed;
    logic [bapp_pkg::ELAP_W+bapp_pkg::RECIP_W-1:0]        w_prod;
    logic [bapp_pkg::BIT_IDX_W-1:0]                       w_bit_idx;

    assign w_word    = i_sel.start ? i_sel.word : i_cur.pattern_word;
    assign w_stime   = i_sel.start ? i_item.now_ms : i_cur.start_time;
    assign w_elapsed = i_item.now_ms - w_stime;

    assign w_prod    = {{bapp_pkg::RECIP_W{1'b0}}, w_elapsed[bapp_pkg::ELAP_W-1:0]}
                     * {{bapp_pkg::ELAP_W{1'b0}}, bapp_pkg::RECIP_100};
    // 31 - bit is the bitwise inverse of a 5-bit bit number
    assign w_bit_idx = ~w_prod[bapp_pkg::RECIP_SHIFT +: bapp_pkg::BIT_IDX_W];

    always_comb begin
        o_next = i_cur;
        if (i_item.mode) begin
            o_next.buzz_on = 1'b0;
        end else begin
            o_next.pattern_word = w_word;
            o_next.start_time   = w_stime;
            if (w_word != '0) begin
                if (w_elapsed >= bapp_pkg::PLAY_LEN_MS) begin
                    o_next.buzz_on      = 1'b0;
                    o_next.pattern_word = '0;
                end else begin
                    o_next.buzz_on = w_word[w_bit_idx];
                end
            end
        end
    end

endmodule

FILE: tb/tb_buzzer_alert_pattern_player.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_buzzer_alert_pattern_player
// Self-checking bench for the buzzer alert pattern player. Status ticks and
// init words go in on the input stream. A behavioural predictor works out
// the pin level, buzzer state and busy flag for every accepted word. Results
// leaving the output stream are checked in order against those predictions.
// Runs a directed sequence, then random status streams under several register
// settings, with bursty input, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_buzzer_alert_pattern_player;

    // status flag masks, bit order as packed above now_ms in tdata
    localparam logic [6:0] F_ARMFAIL = 7'h01;
    localparam logic [6:0] F_GYRO    = 7'h02;
    localparam logic [6:0] F_PREARM  = 7'h04;
    localparam logic [6:0] F_ARMED   = 7'h08;
    localparam logic [6:0] F_EKF     = 7'h10;
    localparam logic [6:0] F_LOST    = 7'h20;
    localparam logic [6:0] F_BATT    = 7'h40;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_INIT = 1'b1;

    typedef struct packed {
        logic busy_res;
        logic sounding;
        logic pin_level;
    } t_buzz_res;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [bapp_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                            s_axis_tuser  = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [bapp_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            i_cfg_wr_en   = 1'b0;
    logic [bapp_pkg::CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [bapp_pkg::WORD_W-1:0]     i_cfg_wdata   = '0;

    // predictor copy of the registers and state
    bapp_pkg::t_cfg              m_cfg;
    logic                        m_active;
    logic [bapp_pkg::WORD_W-1:0] m_word;
    logic [bapp_pkg::WORD_W-1:0] m_start;
    bapp_pkg::t_seen             m_seen;
    logic                        m_buzz;

    t_buzz_res buzz_exp_q[$];
    int        err_cnt      = 0;
    int        rx_stall_pct = 0;
    int        rx_hold      = 0;

    // random status stream state
    logic [bapp_pkg::WORD_W-1:0] g_now = '0;
    logic [6:0]                  g_fl  = '0;

    buzzer_alert_pattern_player uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("tb_buzzer_alert_pattern_player NOT OK");
        $finish;
    end

    function automatic bapp_pkg::t_item make_item(input logic mode,
                                                  input logic [bapp_pkg::WORD_W-1:0] now,
                                                  input logic [6:0] fl);
        bapp_pkg::t_item it;
        it.mode             = mode;
        it.now_ms           = now;
        it.arm_failed_event = fl[0];
        it.gyro_cal_flag    = fl[1];
        it.prearm_ok_flag   = fl[2];
        it.armed_flag       = fl[3];
        it.ekf_bad_flag     = fl[4];
        it.lost_flag        = fl[5];
        it.battery_fs_flag  = fl[6];
        return it;
    endfunction

    // selection by priority, then playback of the current word
    function automatic t_buzz_res predict_buzzer(input bapp_pkg::t_item it);
        logic [bapp_pkg::WORD_W-1:0] elapsed;
        int unsigned                 slot;
        t_buzz_res                   r;
        if (it.mode == MODE_INIT) begin
            m_seen.seen_armed = it.armed_flag;
            m_buzz            = 1'b0;
        end else begin
            elapsed = it.now_ms - m_start;
            if (it.arm_failed_event) begin
                m_word  = m_cfg.single_pattern;
                m_start = it.now_ms;
            end else if (elapsed >= m_cfg.min_gap_ms) begin
                if (m_seen.seen_gyro_cal != it.gyro_cal_flag) begin
                    m_seen.seen_gyro_cal = it.gyro_cal_flag;
                    m_word  = m_cfg.gyro_init_pattern;
                    m_start = it.now_ms;
                end
                if (it.prearm_ok_flag && !m_seen.seen_prearm_ok) begin
                    m_seen.seen_prearm_ok = 1'b1;
                    m_word  = m_cfg.prearm_good_pattern;
                    m_start = it.now_ms;
                end
                // armed and ekf changes end the selection
                if (m_seen.seen_armed != it.armed_flag) begin
                    m_seen.seen_armed = it.armed_flag;
                    m_word  = it.armed_flag ? m_cfg.arming_pattern : m_cfg.single_pattern;
                    m_start = it.now_ms;
                end else if (m_seen.seen_ekf_bad != it.ekf_bad_flag) begin
                    m_seen.seen_ekf_bad = it.ekf_bad_flag;
                    if (it.ekf_bad_flag) begin
                        m_word  = m_cfg.ekf_bad_pattern;
                        m_start = it.now_ms;
                    end
                end else if (it.lost_flag) begin
                    m_word  = m_cfg.double_pattern;
                    m_start = it.now_ms;
                end else if (it.battery_fs_flag) begin
                    m_word  = m_cfg.single_pattern;
                    m_start = it.now_ms;
                end
            end
            if (m_word != '0) begin
                elapsed = it.now_ms - m_start;
                if (elapsed >= bapp_pkg::PLAY_LEN_MS) begin
                    m_buzz = 1'b0;
                    m_word = '0;
                end else begin
                    slot   = elapsed / bapp_pkg::BIT_MS;
                    m_buzz = m_word[31 - slot];
                end
            end
        end
        r.pin_level = m_buzz ? m_active : ~m_active;
        r.sounding  = m_buzz;
        r.busy_res  = (m_word != '0);
        return r;
    endfunction

    task automatic send_item(input bapp_pkg::t_item it);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.mode;
        s_axis_tdata  <= {1'b0, it.battery_fs_flag, it.lost_flag, it.ekf_bad_flag,
                          it.armed_flag, it.prearm_ok_flag, it.gyro_cal_flag,
                          it.arm_failed_event, it.now_ms};
        do @(posedge i_clk); while (!s_axis_tready);
        buzz_exp_q.push_back(predict_buzzer(it));
    endtask

    task automatic pause_tx(input int n);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (buzz_exp_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input bapp_pkg::t_cfg_idx idx,
                             input logic [bapp_pkg::WORD_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            bapp_pkg::CFG_SINGLE:      m_cfg.single_pattern      = val;
            bapp_pkg::CFG_DOUBLE:      m_cfg.double_pattern      = val;
            bapp_pkg::CFG_ARMING:      m_cfg.arming_pattern      = val;
            bapp_pkg::CFG_EKF_BAD:     m_cfg.ekf_bad_pattern     = val;
            bapp_pkg::CFG_GYRO_INIT:   m_cfg.gyro_init_pattern   = val;
            bapp_pkg::CFG_PREARM_GOOD: m_cfg.prearm_good_pattern = val;
            bapp_pkg::CFG_MIN_GAP:     m_cfg.min_gap_ms          = val;
            bapp_pkg::CFG_ACTIVE_LVL:  m_active                  = val[0];
            default: ;
        endcase
    endtask

    // mostly plausible status streams, some pure noise words
    function automatic bapp_pkg::t_item next_random_item();
        logic [bapp_pkg::WORD_W-1:0] step;
        logic [6:0]                  rnd_fl;
        logic                        armfail;
        logic                        mode;
        int                          r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            rnd_fl = 7'($urandom());
            return make_item(1'($urandom_range(0, 1)), $urandom(), rnd_fl);
        end
        r = $urandom_range(0, 99);
        if (r < 5)       step = '0;
        else if (r < 75) step = $urandom_range(1, 60);
        else if (r < 95) step = $urandom_range(61, 400);
        else             step = $urandom();
        g_now = g_now + step;
        for (int b = 1; b <= 4; b++)
            if ($urandom_range(0, 99) < 4) g_fl[b] = ~g_fl[b];
        for (int b = 5; b <= 6; b++) begin
            if (g_fl[b]) begin
                if ($urandom_range(0, 99) < 20) g_fl[b] = 1'b0;
            end else if ($urandom_range(0, 99) < 3) begin
                g_fl[b] = 1'b1;
            end
        end
        armfail = ($urandom_range(0, 99) < 3);
        mode    = ($urandom_range(0, 99) < 3) ? MODE_INIT : MODE_TICK;
        return make_item(mode, g_now, {g_fl[6:1], armfail});
    endfunction

    task automatic run_random(input int n, input bit with_gaps);
        int burst;
        burst = 0;
        for (int i = 0; i < n; i++) begin
            if (with_gaps) begin
                if (burst == 0) begin
                    burst = $urandom_range(1, 24);
                    if ($urandom_range(0, 1) != 0) pause_tx($urandom_range(1, 8));
                end
                burst--;
            end
            send_item(next_random_item());
        end
    endtask

    function automatic logic [bapp_pkg::WORD_W-1:0] pick_word(input int k);
        if (k == 1) return '1;
        if (k == 2) return '0;
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_directed();
        logic [6:0] b1;
        logic [6:0] b2;
        b1 = F_GYRO | F_PREARM | F_ARMED;
        b2 = F_PREARM | F_ARMED;
        rx_stall_pct = 0;
        write_cfg(bapp_pkg::CFG_SINGLE,      32'hAAAA_AAAA);
        write_cfg(bapp_pkg::CFG_DOUBLE,      32'hCCCC_CCCC);
        write_cfg(bapp_pkg::CFG_ARMING,      32'hFFFF_0000);
        write_cfg(bapp_pkg::CFG_EKF_BAD,     32'h8000_0001);
        write_cfg(bapp_pkg::CFG_GYRO_INIT,   32'h0F0F_0F0F);
        write_cfg(bapp_pkg::CFG_PREARM_GOOD, 32'h0000_0000);
        write_cfg(bapp_pkg::CFG_MIN_GAP,     32'd0);
        write_cfg(bapp_pkg::CFG_ACTIVE_LVL,  32'd1);
        send_item(make_item(MODE_INIT, 32'hDEAD_BEEF, 7'h7F & ~F_ARMFAIL & F_ARMED));
        send_item(make_item(MODE_TICK, 32'd1000, F_ARMED));
        send_item(make_item(MODE_TICK, 32'd1000, F_ARMED | F_ARMFAIL));
        send_item(make_item(MODE_TICK, 32'd1150, F_ARMED));
        send_item(make_item(MODE_TICK, 32'd1200, F_ARMED | F_GYRO));
        // zero prearm word takes over: no pattern, buzzer kept
        send_item(make_item(MODE_TICK, 32'd1220, b1));
        send_item(make_item(MODE_TICK, 32'd1300, F_GYRO | F_PREARM));
        // armed change wins over ekf in the same tick
        send_item(make_item(MODE_TICK, 32'd1400, b1 | F_EKF));
        send_item(make_item(MODE_TICK, 32'd1500, b1 | F_EKF));
        send_item(make_item(MODE_TICK, 32'd1600, b1));
        send_item(make_item(MODE_TICK, 32'd1700, b1 | F_LOST | F_BATT));
        send_item(make_item(MODE_TICK, 32'd1800, b1 | F_BATT));
        send_item(make_item(MODE_TICK, 32'd4999, b1));
        send_item(make_item(MODE_TICK, 32'd5000, b1));
        send_item(make_item(MODE_TICK, 32'd5000, b1 | F_ARMFAIL));
        send_item(make_item(MODE_INIT, 32'd5050, F_ARMED));
        send_item(make_item(MODE_TICK, 32'd5100, b1));
        // gyro start overwritten by lost in the same tick
        send_item(make_item(MODE_TICK, 32'd5200, b2 | F_LOST));
        // start just before the time wraps
        send_item(make_item(MODE_TICK, 32'hFFFF_FFC0, b2 | F_ARMFAIL));
        send_item(make_item(MODE_TICK, 32'h0000_0050, b2));
        drain_results();
        write_cfg(bapp_pkg::CFG_MIN_GAP, 32'd500);
        send_item(make_item(MODE_TICK, 32'h0000_0100, b2 | F_LOST));
        send_item(make_item(MODE_TICK, 32'h0000_0110, b2 | F_ARMFAIL));
        send_item(make_item(MODE_TICK, 32'h0000_0120, b2 | F_BATT));
        send_item(make_item(MODE_TICK, 32'h0000_0400, b2 | F_BATT));
        drain_results();
        write_cfg(bapp_pkg::CFG_ACTIVE_LVL, 32'd0);
        send_item(make_item(MODE_TICK, 32'h0000_0410, b2));
        g_now = 32'h0000_0410;
        g_fl  = b2;
    endtask

    task automatic test_setting_sweep();
        logic [bapp_pkg::WORD_W-1:0] gap;
        for (int k = 0; k < 6; k++) begin
            drain_results();
            case (k)
                0:       gap = 32'd0;
                1:       gap = 32'hFFFF_FFFF;
                2:       gap = bapp_pkg::PLAY_LEN_MS;
                3:       gap = 32'd250;
                4:       gap = $urandom_range(0, 5000);
                default: gap = bapp_pkg::PLAY_LEN_MS - 1;
            endcase
            write_cfg(bapp_pkg::CFG_SINGLE,      pick_word(k));
            write_cfg(bapp_pkg::CFG_DOUBLE,      pick_word(k));
            write_cfg(bapp_pkg::CFG_ARMING,      pick_word(k));
            write_cfg(bapp_pkg::CFG_EKF_BAD,     pick_word(k));
            write_cfg(bapp_pkg::CFG_GYRO_INIT,   pick_word(k));
            write_cfg(bapp_pkg::CFG_PREARM_GOOD, pick_word(k));
            write_cfg(bapp_pkg::CFG_MIN_GAP,     gap);
            write_cfg(bapp_pkg::CFG_ACTIVE_LVL,  32'(k % 2));
            if (k == 3) g_now = 32'hFFFF_F800 + $urandom_range(0, 1023);
            // first setting runs flat out on both sides
            rx_stall_pct = (k == 0) ? 0 : $urandom_range(10, 60);
            run_random(200, k != 0);
        end
    endtask

    task automatic test_backpressure();
        rx_stall_pct = 0;
        rx_hold      = 400;
        run_random(60, 1'b0);
        drain_results();
        rx_stall_pct = 30;
        run_random(40, 1'b1);
    endtask

    // receiver: random stalls, or a counted hold-off when asked
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin : chk
        t_buzz_res exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (buzz_exp_q.size() == 0) begin
                $error("result word with no expectation: tdata=%h", m_axis_tdata);
                err_cnt++;
            end else begin
                exp_r = buzz_exp_q.pop_front();
                if (m_axis_tdata[0] !== exp_r.pin_level) begin
                    $error("pin_level: expected %b, got %b", exp_r.pin_level, m_axis_tdata[0]);
                    err_cnt++;
                end
                if (m_axis_tdata[1] !== exp_r.sounding) begin
                    $error("sounding: expected %b, got %b", exp_r.sounding, m_axis_tdata[1]);
                    err_cnt++;
                end
                if (m_axis_tdata[2] !== exp_r.busy_res) begin
                    $error("busy_res: expected %b, got %b", exp_r.busy_res, m_axis_tdata[2]);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        m_cfg    = '0;
        m_active = 1'b1;
        m_word   = '0;
        m_start  = '0;
        m_seen   = '0;
        m_buzz   = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_setting_sweep();
        test_backpressure();
        drain_results();
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0)
            $display("tb_buzzer_alert_pattern_player OK");
        else
            $display("tb_buzzer_alert_pattern_player NOT OK");
        $finish;
    end

endmodule
